// ===== hdl/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// shared widths, request codes, register indexes and arithmetic constants
// for the display mode scheduler
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int MODE_W  = 3;
    localparam int REQ_W   = 2;
    localparam int FRAME_W = 32;
    localparam int HHMM_W  = 12;
    localparam int TIME_W  = 16;
    localparam int IVL_W   = 11;
    localparam int MASK_W  = 7;
    localparam int CFG_W   = 12;
    localparam int CIDX_W  = 3;

    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [REQ_W-1:0]   t_req;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [HHMM_W-1:0]  t_hhmm;
    typedef logic [TIME_W-1:0]  t_time;

    // request codes
    localparam t_req REQ_TICK   = 2'd0;
    localparam t_req REQ_SET    = 2'd1;
    localparam t_req REQ_CANCEL = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_STARTUP  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SLEEP    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_WAKE     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_INTERVAL = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MASK     = 3'd4;

    localparam t_time NONE_TIME = 16'hFFFF;
    localparam logic [MASK_W-1:0] MASK_RESET = 7'd127;

    // reciprocal constants: x/100 = (x*5243)>>19 for x < 43699,
    // x/60 = (x*4370)>>18 for x < 2147 (all values met here)
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [12:0] RECIP_60  = 13'd4370;
    localparam int SHIFT_100 = 19;
    localparam int SHIFT_60  = 18;

endpackage

// ===== hdl/dms_item_if.sv =====
// ----------------------------------------------------------------------------
// dms_item_if
// request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
interface dms_item_if;
    import dms_pkg::*;

    logic   valid;
    logic   ready;
    t_req   req_type;
    logic   increment_pressed;
    logic   select_pressed;
    t_frame frame_number;
    t_hhmm  wall_time;
    t_mode  new_mode;

    modport source (
        output valid, req_type, increment_pressed, select_pressed,
               frame_number, wall_time, new_mode,
        input  ready
    );
    modport sink (
        input  valid, req_type, increment_pressed, select_pressed,
               frame_number, wall_time, new_mode,
        output ready
    );
endinterface

// ===== hdl/dms_result_if.sv =====
// ----------------------------------------------------------------------------
// dms_result_if
// result channel: valid/ready handshake with the render fields
// ----------------------------------------------------------------------------
interface dms_result_if;
    import dms_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  render_mode;
    t_frame relative_frame;
    logic   enter_set_time;

    modport source (
        output valid, render_mode, relative_frame, enter_set_time,
        input  ready
    );
    modport sink (
        input  valid, render_mode, relative_frame, enter_set_time,
        output ready
    );
endinterface

// ===== hdl/display_mode_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// display_mode_scheduler_unit
// per-frame display mode selector: startup load, sleep/wake edges, timed
// advance over enabled modes with decimal HHMM wrap, button handling
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake            payload
//  i_item     in   valid/ready          req_type, buttons, frame, time, mode
//  o_result   out  valid/ready          render_mode, relative_frame, set-time
//  i_cfg_*    in   write enable only    register index, 12-bit data
//
//  one item at a time; a set or cancel request goes from idle straight to
//  the output step, a frame tick through the prep and auto steps, the
//  enabled-mode search when due and the next-change-time steps DIVA to
//  DIVD when needed, both divisions through one shared multiplier
//  synchronous active-low reset clears the mode state and the registers
//  the output register holds a result until taken; a stalled result holds
//  the sequencer in its output step, so no further item is taken meanwhile
//
module display_mode_scheduler_unit #(
    parameter int NUM_MODES = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dms_item_if.sink               i_item,
    dms_result_if.source           o_result,
    input  logic                   i_cfg_we,
    input  logic [dms_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [dms_pkg::CFG_W-1:0]  i_cfg_data
);
    import dms_pkg::*;

    // last mode is the "off" mode
    localparam t_mode OFF_MODE = MODE_W'(NUM_MODES - 1);
    localparam logic [MODE_W:0] NUM_MODES_W = (MODE_W+1)'(NUM_MODES);

    // sequencer steps
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;  // startup load, frame zero, sleep/wake
    localparam logic [3:0] S_AUTO   = 4'd2;  // decide on timed advance
    localparam logic [3:0] S_SEARCH = 4'd3;  // one mode step a cycle
    localparam logic [3:0] S_CHK    = 4'd4;  // need a new change time?
    localparam logic [3:0] S_DIVA   = 4'd5;  // hours part of time
    localparam logic [3:0] S_DIVB   = 4'd6;  // minutes plus interval
    localparam logic [3:0] S_DIVC   = 4'd7;  // carried hours
    localparam logic [3:0] S_DIVD   = 4'd8;  // wrap and pack HHMM
    localparam logic [3:0] S_OUT    = 4'd9;  // load result, apply increment

    // configuration
    t_mode               r_startup_mode;
    t_hhmm               r_sleep_time;
    t_hhmm               r_wake_time;
    logic [IVL_W-1:0]    r_interval;
    logic [MASK_W-1:0]   r_mask;

    // scheduler state
    logic [3:0] r_state, n_state;
    t_mode      r_mode, n_mode;
    t_mode      r_wake_mode, n_wake_mode;
    logic       r_started, n_started;
    t_time      r_last_edge, n_last_edge;
    t_time      r_next_change, n_next_change;
    t_frame     r_frame_base, n_frame_base;

    // latched request and working registers
    logic       r_tick, n_tick;
    logic       r_inc, n_inc;
    logic       r_sel, n_sel;
    t_frame     r_frame, n_frame;
    t_hhmm      r_t, n_t;
    logic [MODE_W-1:0] r_cnt, n_cnt;
    logic [5:0] r_q, n_q;         // time / 100
    logic [11:0] r_min, n_min;    // time % 100 + interval
    logic [5:0] r_hq, n_hq;       // r_min / 60

    // result register
    logic       r_out_valid, n_out_valid;
    t_mode      r_out_mode, n_out_mode;
    t_frame     r_out_rel, n_out_rel;
    logic       r_out_set, n_out_set;

    // shared multiplier
    logic [11:0] mul_a;
    logic [12:0] mul_b;
    logic [24:0] mul_p;

    // helpers
    t_mode             adv_mode;
    logic [MASK_W:0]   mask_ext;
    logic [6:0]        rem_min;
    logic [5:0]        wrap_min;
    logic [6:0]        hours;
    logic [4:0]        hours_w;
    logic              accept;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid          = r_out_valid;
    assign o_result.render_mode    = r_out_mode;
    assign o_result.relative_frame = r_out_rel;
    assign o_result.enter_set_time = r_out_set;

    assign mul_a = (r_state == S_DIVA) ? r_t : r_min;
    assign mul_b = (r_state == S_DIVA) ? RECIP_100 : RECIP_60;
    assign mul_p = 25'(mul_a) * 25'(mul_b);

    // next mode with wrap at the mode count
    assign adv_mode = (r_mode >= OFF_MODE) ? '0 : r_mode + 1'b1;
    assign mask_ext = {1'b0, r_mask};

    // HHMM packing pieces
    assign rem_min  = 7'(r_t - 12'(r_q) * 12'd100);
    assign wrap_min = 6'(r_min - 12'(r_hq) * 12'd60);
    assign hours    = 7'(r_q) + 7'(r_hq);

    always_comb begin
        if (hours >= 7'd72) begin
            hours_w = 5'(hours - 7'd72);
        end else if (hours >= 7'd48) begin
            hours_w = 5'(hours - 7'd48);
        end else if (hours >= 7'd24) begin
            hours_w = 5'(hours - 7'd24);
        end else begin
            hours_w = 5'(hours);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_wake_mode   = r_wake_mode;
        n_started     = r_started;
        n_last_edge   = r_last_edge;
        n_next_change = r_next_change;
        n_frame_base  = r_frame_base;
        n_tick        = r_tick;
        n_inc         = r_inc;
        n_sel         = r_sel;
        n_frame       = r_frame;
        n_t           = r_t;
        n_cnt         = r_cnt;
        n_q           = r_q;
        n_min         = r_min;
        n_hq          = r_hq;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_mode    = r_out_mode;
        n_out_rel     = r_out_rel;
        n_out_set     = r_out_set;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tick  = (i_item.req_type == REQ_TICK);
                    n_inc   = i_item.increment_pressed;
                    n_sel   = i_item.select_pressed;
                    n_frame = i_item.frame_number;
                    n_t     = i_item.wall_time;
                    if (i_item.req_type == REQ_TICK) begin
                        n_state = S_PREP;
                    end else begin
                        // set and cancel act at once; unused code does nothing
                        if (i_item.req_type == REQ_SET &&
                            {1'b0, i_item.new_mode} < NUM_MODES_W) begin
                            n_mode = i_item.new_mode;
                        end
                        if (i_item.req_type == REQ_CANCEL) begin
                            n_next_change = NONE_TIME;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_PREP: begin
                // first tick after reset loads the startup mode
                if (!r_started) begin
                    n_last_edge   = NONE_TIME;
                    n_next_change = NONE_TIME;
                    n_mode        = ({1'b0, r_startup_mode} < NUM_MODES_W)
                                    ? r_startup_mode : '0;
                    n_wake_mode   = n_mode;
                    n_started     = 1'b1;
                end
                if (r_frame == '0) begin
                    n_frame_base = '0;
                end
                // sleep/wake fire once per time value
                if (r_sleep_time != r_wake_time && n_last_edge != TIME_W'(r_t)) begin
                    if (r_t == r_sleep_time) begin
                        n_mode      = OFF_MODE;
                        n_last_edge = TIME_W'(r_t);
                    end else if (r_t == r_wake_time) begin
                        n_mode      = n_wake_mode;
                        n_last_edge = TIME_W'(r_t);
                    end
                end
                n_state = S_AUTO;
            end
            S_AUTO: begin
                if (r_interval != '0 && r_mode != OFF_MODE) begin
                    n_cnt   = '0;
                    n_state = (TIME_W'(r_t) == r_next_change) ? S_SEARCH : S_CHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SEARCH: begin
                // advance until an enabled mode or a full cycle
                n_mode        = adv_mode;
                n_wake_mode   = adv_mode;
                n_frame_base  = r_frame + 1'b1;
                n_next_change = NONE_TIME;
                n_cnt         = r_cnt + 1'b1;
                if (mask_ext[adv_mode] || r_cnt == MODE_W'(NUM_MODES - 1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = (r_next_change == NONE_TIME) ? S_DIVA : S_OUT;
            end
            S_DIVA: begin
                n_q     = mul_p[SHIFT_100 +: 6];
                n_state = S_DIVB;
            end
            S_DIVB: begin
                n_min   = 12'(rem_min) + 12'(r_interval);
                n_state = S_DIVC;
            end
            S_DIVC: begin
                n_hq    = mul_p[SHIFT_60 +: 6];
                n_state = S_DIVD;
            end
            S_DIVD: begin
                n_next_change = TIME_W'(12'(hours_w) * 12'd100 + 12'(wrap_min));
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_mode  = r_mode;
                    n_out_rel   = r_tick ? r_frame - r_frame_base : '0;
                    n_out_set   = r_tick && r_sel;
                    // increment button acts after the result
                    if (r_tick && r_inc) begin
                        n_mode        = adv_mode;
                        n_wake_mode   = adv_mode;
                        n_frame_base  = r_frame + 1'b1;
                        n_next_change = NONE_TIME;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_mode         <= '0;
            r_wake_mode    <= '0;
            r_started      <= 1'b0;
            r_last_edge    <= NONE_TIME;
            r_next_change  <= NONE_TIME;
            r_frame_base   <= '0;
            r_startup_mode <= '0;
            r_sleep_time   <= '0;
            r_wake_time    <= '0;
            r_interval     <= '0;
            r_mask         <= MASK_RESET;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_mode        <= n_mode;
            r_wake_mode   <= n_wake_mode;
            r_started     <= n_started;
            r_last_edge   <= n_last_edge;
            r_next_change <= n_next_change;
            r_frame_base  <= n_frame_base;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STARTUP:  r_startup_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_SLEEP:    r_sleep_time   <= i_cfg_data[HHMM_W-1:0];
                    CFG_WAKE:     r_wake_time    <= i_cfg_data[HHMM_W-1:0];
                    CFG_INTERVAL: r_interval     <= i_cfg_data[IVL_W-1:0];
                    CFG_MASK:     r_mask         <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_tick     <= n_tick;
        r_inc      <= n_inc;
        r_sel      <= n_sel;
        r_frame    <= n_frame;
        r_t        <= n_t;
        r_cnt      <= n_cnt;
        r_q        <= n_q;
        r_min      <= n_min;
        r_hq       <= n_hq;
        r_out_mode <= n_out_mode;
        r_out_rel  <= n_out_rel;
        r_out_set  <= n_out_set;
    end

endmodule

// ===== dv/mode_schedule_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mode_schedule_checker
// watches the request and render channels and the register port, keeps its
// own copy of the mode schedule state and compares every render item with
// the predicted one, oldest first
// ----------------------------------------------------------------------------
module mode_schedule_checker #(
    parameter int NUM_MODES = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dms_item_if                        i_item,
    dms_result_if                      i_result,
    input  logic                       i_cfg_we,
    input  logic [dms_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [dms_pkg::CFG_W-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_compared
);
    import dms_pkg::*;

    typedef struct packed {
        t_mode  mode;
        t_frame rel_frame;
        logic   set_time;
    } render_t;

    render_t expected_renders[$];

    // schedule state
    t_mode  mode_now;
    t_mode  mode_remembered;
    logic   is_started;
    t_time  edge_time;
    t_time  next_advance;
    t_frame base_frame;

    // register copies
    t_mode              startup_cfg;
    t_hhmm              sleep_cfg;
    t_hhmm              wake_cfg;
    logic [IVL_W-1:0]   interval_cfg;
    logic [MASK_W-1:0]  mask_cfg;

    function automatic void step_mode(input t_frame frame);
        if (int'(mode_now) + 1 >= NUM_MODES) begin
            mode_now = '0;
        end else begin
            mode_now = mode_now + 1'b1;
        end
        mode_remembered = mode_now;
        base_frame      = frame + 1'b1;
        next_advance    = NONE_TIME;
    endfunction

    function automatic render_t schedule_item(input t_req req, input logic inc,
                                              input logic sel, input t_frame frame,
                                              input t_hhmm t, input t_mode nm);
        t_mode   off_mode;
        render_t r;
        int      mins;
        int      hrs;
        off_mode = t_mode'(NUM_MODES - 1);
        if (req != REQ_TICK) begin
            if (req == REQ_SET) begin
                if (int'(nm) < NUM_MODES) mode_now = nm;
            end else if (req == REQ_CANCEL) begin
                next_advance = NONE_TIME;
            end
            r.mode      = mode_now;
            r.rel_frame = '0;
            r.set_time  = 1'b0;
            return r;
        end

        if (!is_started) begin
            edge_time       = NONE_TIME;
            next_advance    = NONE_TIME;
            mode_now        = (int'(startup_cfg) < NUM_MODES) ? startup_cfg : '0;
            mode_remembered = mode_now;
            is_started      = 1'b1;
        end
        if (frame == '0) base_frame = '0;

        if (sleep_cfg != wake_cfg && edge_time != {4'b0, t}) begin
            if (t == sleep_cfg) begin
                mode_now  = off_mode;
                edge_time = {4'b0, t};
            end else if (t == wake_cfg) begin
                mode_now  = mode_remembered;
                edge_time = {4'b0, t};
            end
        end

        if (interval_cfg != '0 && mode_now != off_mode) begin
            if ({4'b0, t} == next_advance) begin
                for (int n = 0; n < NUM_MODES; n++) begin
                    step_mode(frame);
                    if (int'(mode_now) < MASK_W && mask_cfg[mode_now]) break;
                end
            end
            if (next_advance == NONE_TIME) begin
                mins = int'(t) % 100 + int'(interval_cfg);
                hrs  = int'(t) / 100 + mins / 60;
                mins = mins % 60;
                next_advance = t_time'((hrs % 24) * 100 + mins);
            end
        end

        r.mode      = mode_now;
        r.rel_frame = frame - base_frame;
        r.set_time  = sel;
        if (inc) step_mode(frame);
        return r;
    endfunction

    always @(posedge i_clk) begin
        render_t want;
        if (!i_rst_n) begin
            mode_now        = '0;
            mode_remembered = '0;
            is_started      = 1'b0;
            edge_time       = NONE_TIME;
            next_advance    = NONE_TIME;
            base_frame      = '0;
            startup_cfg     = '0;
            sleep_cfg       = '0;
            wake_cfg        = '0;
            interval_cfg    = '0;
            mask_cfg        = MASK_RESET;
            expected_renders.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STARTUP:  startup_cfg  = i_cfg_data[MODE_W-1:0];
                    CFG_SLEEP:    sleep_cfg    = i_cfg_data[HHMM_W-1:0];
                    CFG_WAKE:     wake_cfg     = i_cfg_data[HHMM_W-1:0];
                    CFG_INTERVAL: interval_cfg = i_cfg_data[IVL_W-1:0];
                    CFG_MASK:     mask_cfg     = i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end

            if (i_result.valid && i_result.ready) begin
                o_compared = o_compared + 1;
                if (expected_renders.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: render item with nothing expected: mode %0d rel %0d set %0b",
                                 $realtime, i_result.render_mode, i_result.relative_frame,
                                 i_result.enter_set_time);
                end else begin
                    want = expected_renders.pop_front();
                    if (want.mode !== i_result.render_mode
                        || want.rel_frame !== i_result.relative_frame
                        || want.set_time !== i_result.enter_set_time) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display({"%0t: render mismatch: expected mode %0d rel %0d set %0b,",
                                      " got mode %0d rel %0d set %0b"},
                                     $realtime, want.mode, want.rel_frame, want.set_time,
                                     i_result.render_mode, i_result.relative_frame,
                                     i_result.enter_set_time);
                    end
                end
            end

            if (i_item.valid && i_item.ready)
                expected_renders.push_back(schedule_item(i_item.req_type,
                    i_item.increment_pressed, i_item.select_pressed,
                    i_item.frame_number, i_item.wall_time, i_item.new_mode));
        end
        o_pending = expected_renders.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the display mode scheduler with a walking wall clock, button
// presses, set and cancel requests and noise, across several register
// settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
    import dms_pkg::*;

    localparam int   NUM_MODES   = 7;
    localparam int   PHASES      = 10;
    localparam int   PHASE_ITEMS = 145;
    localparam int   HOLD_CYCLES = 300;
    localparam t_req REQ_UNUSED  = 2'd3;   // code with no meaning, must change nothing

    logic clk = 1'b0;
    logic rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int compared;

    // gap control, shared by the sender and the receiver process
    bit tx_gaps;
    bit rx_gaps;
    bit hold_request;

    // tallies for the summary
    int n_ticks;
    int n_sets;
    int n_cancels;
    int n_unused;
    int n_settings;

    dms_item_if   item_ch ();
    dms_result_if result_ch ();

    always #5 clk = ~clk;

    display_mode_scheduler_unit #(
        .NUM_MODES (NUM_MODES)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mode_schedule_checker #(
        .NUM_MODES (NUM_MODES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    // wall clock arithmetic for the stimulus, wraps at midnight
    function automatic t_hhmm later_hhmm(input t_hhmm t, input int m);
        int total;
        total = (int'(t) / 100) * 60 + int'(t) % 100 + m;
        total = total % 1440;
        if (total < 0) total = total + 1440;
        return t_hhmm'((total / 60) * 100 + total % 60);
    endfunction

    // offer one item, hold it until the block takes it
    task automatic send_item(input t_req req, input logic inc, input logic sel,
                             input t_frame frame, input t_hhmm t, input t_mode nm);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        item_ch.valid             <= 1'b1;
        item_ch.req_type          <= req;
        item_ch.increment_pressed <= inc;
        item_ch.select_pressed    <= sel;
        item_ch.frame_number      <= frame;
        item_ch.wall_time         <= t;
        item_ch.new_mode          <= nm;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
        case (req)
            REQ_TICK:   n_ticks++;
            REQ_SET:    n_sets++;
            REQ_CANCEL: n_cancels++;
            default:    n_unused++;
        endcase
    endtask

    // stop offering and wait until every render item has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // write all five registers, one per cycle, only while idle
    task automatic apply_settings(input int startup, input int sleep_t, input int wake_t,
                                  input int ivl, input int mask);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STARTUP;
        cfg_data <= CFG_W'(startup);
        @(negedge clk);
        cfg_idx  <= CFG_SLEEP;
        cfg_data <= CFG_W'(sleep_t);
        @(negedge clk);
        cfg_idx  <= CFG_WAKE;
        cfg_data <= CFG_W'(wake_t);
        @(negedge clk);
        cfg_idx  <= CFG_INTERVAL;
        cfg_data <= CFG_W'(ivl);
        @(negedge clk);
        cfg_idx  <= CFG_MASK;
        cfg_data <= CFG_W'(mask);
        @(negedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // render side: random stalls, plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                // long hold-off so the block backs up into the request channel
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                result_ch.ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // run limit, several times the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout: %0d render items still outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int     pick;
        int     sleep_t;
        int     wake_t;
        int     ivl;
        int     mask;
        t_hhmm  clock_hhmm;
        t_frame frame_ctr;

        // every input known from time zero
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_idx                   = '0;
        cfg_data                  = '0;
        item_ch.valid             = 1'b0;
        item_ch.req_type          = REQ_TICK;
        item_ch.increment_pressed = 1'b0;
        item_ch.select_pressed    = 1'b0;
        item_ch.frame_number      = '0;
        item_ch.wall_time         = '0;
        item_ch.new_mode          = '0;
        tx_gaps                   = 1'b1;
        rx_gaps                   = 1'b1;
        hold_request              = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed part ----------------
        // startup mode is only ever loaded once, so pick out of range or not
        apply_settings($urandom_range(0, 1) ? 7 : $urandom_range(1, 6), 1200, 1230, 2, 127);
        send_item(REQ_SET,    1'b0, 1'b0, 5, 0, 3);        // set before the first tick
        send_item(REQ_CANCEL, 1'b1, 1'b1, 9, 0, 0);        // buttons ignored on a cancel
        send_item(REQ_UNUSED, 1'b1, 1'b1, 7, 100, 5);      // unused code is a no-op
        send_item(REQ_TICK,   1'b0, 1'b1, 0, 1158, 0);     // first tick loads startup
        send_item(REQ_TICK,   1'b1, 1'b0, 1, 1159, 0);     // increment after the answer
        send_item(REQ_TICK,   1'b0, 1'b0, 2, 1200, 0);     // sleep edge, off mode
        send_item(REQ_TICK,   1'b0, 1'b0, 3, 1200, 0);     // same minute, no new edge
        send_item(REQ_SET,    1'b0, 1'b0, 0, 0, 7);        // out of range, ignored
        send_item(REQ_TICK,   1'b0, 1'b0, 4, 1230, 0);     // wake edge restores mode
        send_item(REQ_TICK,   1'b0, 1'b0, 5, 1231, 0);
        send_item(REQ_TICK,   1'b0, 1'b1, 6, 1232, 0);     // timed advance
        send_item(REQ_CANCEL, 1'b0, 1'b0, 0, 0, 0);
        send_item(REQ_TICK,   1'b0, 1'b0, 7, 1234, 0);
        send_item(REQ_TICK,   1'b1, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 7);  // time above 2359
        send_item(REQ_TICK,   1'b0, 1'b0, 0, 0, 0);        // frame zero clears the base
        drain_results();

        // empty enable mask, search goes full circle; sleep equal wake disables
        apply_settings(0, 2359, 2359, 1, 0);
        send_item(REQ_SET,  1'b0, 1'b0, 0, 0, 2);
        send_item(REQ_TICK, 1'b0, 1'b0, 10, 2358, 0);
        send_item(REQ_TICK, 1'b0, 1'b0, 11, 2359, 0);      // midnight wrap of next time
        send_item(REQ_TICK, 1'b0, 1'b0, 12, 0, 0);
        drain_results();

        // longest interval, single enabled mode, sleep at midnight
        apply_settings(6, 0, 2359, 1439, 7'b0100000);
        send_item(REQ_TICK, 1'b0, 1'b0, 20, 0, 0);
        send_item(REQ_TICK, 1'b0, 1'b0, 21, 2359, 0);
        send_item(REQ_TICK, 1'b0, 1'b0, 22, 2358, 0);
        send_item(REQ_SET,  1'b0, 1'b0, 0, 0, 6);          // off mode skips the timer
        send_item(REQ_TICK, 1'b0, 1'b1, 23, 2357, 0);
        drain_results();

        // ---------------- random part ----------------
        for (int p = 0; p < PHASES; p++) begin
            clock_hhmm = later_hhmm(12'd0, $urandom_range(0, 1439));
            sleep_t    = int'(later_hhmm(clock_hhmm, $urandom_range(3, 30)));
            wake_t     = int'(later_hhmm(t_hhmm'(sleep_t), $urandom_range(3, 30)));
            ivl        = $urandom_range(1, 6);
            mask       = $urandom_range(0, 127);
            case (p)
                0: mask = 127;
                1: ivl  = 0;                    // timed advance off
                2: begin                        // extremes, run across midnight
                    clock_hhmm = 12'd2350;
                    sleep_t    = 0;
                    wake_t     = 2359;
                    ivl        = 1439;
                    mask       = 127;
                end
                3: begin
                    mask = 0;
                    ivl  = 2;
                end
                4: wake_t = sleep_t;            // sleep and wake both off
                default: ;
            endcase
            apply_settings($urandom_range(0, 7), sleep_t, wake_t, ivl, mask);

            // no idling at all in the closing phases
            tx_gaps   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            rx_gaps   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            frame_ctr = (p == 7) ? 32'hFFFF_FF80 : t_frame'($urandom);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == 60) hold_request = 1'b1;
                if (p == 6 && k == 70) drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    // well-formed frame: clock walks one minute now and then
                    if ($urandom_range(0, 2) == 0) clock_hhmm = later_hhmm(clock_hhmm, 1);
                    frame_ctr = ($urandom_range(0, 99) == 0) ? '0 : frame_ctr + 1'b1;
                    send_item(REQ_TICK, $urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0,
                              frame_ctr, clock_hhmm, 3'($urandom_range(0, 7)));
                end else if (pick < 86) begin
                    send_item(REQ_SET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom, 12'($urandom_range(0, 4095)),
                              3'($urandom_range(0, 7)));
                end else if (pick < 90) begin
                    send_item(REQ_CANCEL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom, 12'($urandom_range(0, 4095)),
                              3'($urandom_range(0, 7)));
                end else if (pick < 92) begin
                    send_item(REQ_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom, 12'($urandom_range(0, 4095)),
                              3'($urandom_range(0, 7)));
                end else begin
                    // noise frame: any time, odd frame numbers
                    pick = $urandom_range(0, 3);
                    send_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom,
                              12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
                end
            end
            drain_results();
        end

        // catch any stray render item
        repeat (30) @(negedge clk);

        $display("covered %0d items: %0d frame ticks, %0d set, %0d cancel, %0d unused code",
                 n_ticks + n_sets + n_cancels + n_unused, n_ticks, n_sets, n_cancels, n_unused);
        $display("%0d register settings, %0d render items compared, %0d failures",
                 n_settings, compared, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
